@@ hw/rtl/sfe_pkg.sv @@
// shared types and constants of the stereo feedback echo
package sfe_pkg;

    localparam int GAIN_W     = 17;
    localparam int DELAY_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam int CMP_W      = 17;
    localparam int SCALE      = 16;

    localparam logic [CFG_IDX_W-1:0] REG_DELAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 2'd1;

    localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd4800;
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 17'd13107;
    localparam logic [GAIN_W-1:0]  GAIN_ONE    = 17'h10000;
    localparam logic [CMP_W-1:0]   LEN_MIN     = 17'd1;

    typedef struct packed {
        logic s1_load;
        logic s2_load;
        logic lw_load;
        logic s2_hit;
        logic lw_hit;
        logic written;
    } lane_ctrl_t;

endpackage

@@ hw/rtl/sfe_ram.sv @@
// generic single write port ram with registered read
module sfe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32768
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hw/rtl/sfe_lane.sv @@
// one channel lane: echo tap select, gain multiply, round and saturate
module sfe_lane #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                              clk,
    input  sfe_pkg::lane_ctrl_t               ctrl,
    input  logic [sfe_pkg::GAIN_W-1:0]        gain,
    input  logic signed [SAMPLE_BITS-1:0]     x_in,
    input  logic signed [SAMPLE_BITS-1:0]     rd_data,
    output logic signed [SAMPLE_BITS-1:0]     y
);

    localparam int PROD_W = SAMPLE_BITS + sfe_pkg::GAIN_W + 1;
    localparam int SUM_W  = SAMPLE_BITS + 2;
    localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) <<< (sfe_pkg::SCALE - 1);
    localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic signed [SAMPLE_BITS-1:0] x1_reg;
    logic signed [SAMPLE_BITS-1:0] x2_reg;
    logic signed [SAMPLE_BITS-1:0] lw_reg;
    logic signed [SAMPLE_BITS-1:0] stored;
    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [PROD_W-1:0]      prod_next;
    logic signed [PROD_W-1:0]      rounded;
    logic signed [SUM_W-1:0]       term;
    logic signed [SUM_W-1:0]       sum;

    // forward words that are not in the ram yet
    always_comb
    begin
        priority if (ctrl.s2_hit)
            stored = y;
        else if (ctrl.lw_hit)
            stored = lw_reg;
        else if (ctrl.written)
            stored = rd_data;
        else
            stored = '0;
    end

    assign prod_next = stored * $signed({1'b0, gain});

    always_ff @(posedge clk)
    begin
        if (ctrl.s1_load)
        begin
            x1_reg <= x_in;
        end
        if (ctrl.s2_load)
        begin
            x2_reg   <= x1_reg;
            prod_reg <= prod_next;
        end
        if (ctrl.lw_load)
        begin
            lw_reg <= y;
        end
    end

    // round to nearest, ties up
    assign rounded = prod_reg + HALF;
    assign term    = rounded[PROD_W-1:sfe_pkg::SCALE];
    assign sum     = {{2{x2_reg[SAMPLE_BITS-1]}}, x2_reg} + term;

    always_comb
    begin
        if (sum[SUM_W-1:SAMPLE_BITS-1] == '0 || sum[SUM_W-1:SAMPLE_BITS-1] == '1)
            y = sum[SAMPLE_BITS-1:0];
        else if (sum[SUM_W-1])
            y = SMIN;
        else
            y = SMAX;
    end

endmodule

@@ hw/rtl/sfe_out.sv @@
// merge of the two lanes into the output register
module sfe_out #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  logic [SAMPLE_BITS-1:0]                 in_left,
    input  logic [SAMPLE_BITS-1:0]                 in_right,
    input  logic                                   in_last,
    output logic                                   in_ready,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     m_axis_tdata,
    output logic                                   m_axis_tlast
);

    localparam int TDATA_W = ((2 * SAMPLE_BITS + 7) / 8) * 8;

    logic               valid_reg;
    logic               valid_next;
    logic [TDATA_W-1:0] data_reg;
    logic               last_reg;

    assign in_ready   = !valid_reg || m_axis_tready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= TDATA_W'({in_right, in_left});
            last_reg <= in_last;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;
    assign m_axis_tlast  = last_reg;

endmodule

@@ hw/rtl/stereo_feedback_echo.sv @@
// top level of the stereo feedback echo
//
// s_axis carries one stereo frame per word: tdata holds left then right
// sample, tlast marks the end of a processing block. m_axis returns one
// word per frame with the echo sums and tlast copied through.
// cfg_we writes delay_frames (index 0) or feedback_gain (index 1) from
// cfg_wdata; only write while no frame is in flight.
// path: each frame passes stage s1, stage s2 and the output register
// throughput: one frame per cycle without stalls; the delay ram takes one
// read and one write per cycle, and pending write-backs are forwarded to
// the reader so frames follow each other without gaps even at delay 1 or 2
// reset: pointer and fill count go to zero, registers to their defaults;
// entries beyond the fill count read as zero, so no clearing pass runs
// and frames are taken from the first cycle after reset
// stall: when m_axis_tready is low the pipeline keeps filling its empty
// stages, then s_axis_tready drops until the output word is taken
module stereo_feedback_echo #(
    parameter int MAX_DELAY_FRAMES = 32768,
    parameter int SAMPLE_BITS      = 16
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    // fields from bit 0: left_in, right_in
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]       s_axis_tdata,
    input  logic                                     s_axis_tlast,
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    // fields from bit 0: left_out, right_out
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]       m_axis_tdata,
    output logic                                     m_axis_tlast,
    input  logic                                     cfg_we,
    input  logic [sfe_pkg::CFG_IDX_W-1:0]            cfg_addr,
    input  logic [sfe_pkg::CFG_DATA_W-1:0]           cfg_wdata
);

    localparam int ADDR_W = $clog2(MAX_DELAY_FRAMES);
    localparam int CMP_W  = sfe_pkg::CMP_W;
    localparam logic [CMP_W-1:0] LEN_MAX = CMP_W'(MAX_DELAY_FRAMES);

    logic [sfe_pkg::DELAY_W-1:0] delay_reg;
    logic [sfe_pkg::GAIN_W-1:0]  gain_reg;
    logic [sfe_pkg::GAIN_W-1:0]  gain_eff;
    logic [CMP_W-1:0]            len_eff;
    logic [CMP_W-1:0]            delay_ext;

    logic [ADDR_W-1:0] pos_reg;
    logic [ADDR_W-1:0] pos_next;
    logic [CMP_W-1:0]  pos_inc;
    logic [CMP_W-1:0]  fill_reg;
    logic [CMP_W-1:0]  fill_next;

    logic              s1_v_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic              s1_written_reg;
    logic              s1_last_reg;
    logic              s2_v_reg;
    logic [ADDR_W-1:0] s2_addr_reg;
    logic              s2_last_reg;
    logic              lw_v_reg;
    logic [ADDR_W-1:0] lw_addr_reg;

    logic out_en;
    logic s2_en;
    logic s1_en;
    logic in_acc;
    logic s1_move;
    logic s2_move;

    logic [2*SAMPLE_BITS-1:0] rd_data;
    logic [SAMPLE_BITS-1:0]   y_left;
    logic [SAMPLE_BITS-1:0]   y_right;

    sfe_pkg::lane_ctrl_t ctrl;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg <= sfe_pkg::DELAY_RESET;
            gain_reg  <= sfe_pkg::GAIN_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_addr == sfe_pkg::REG_DELAY)
                delay_reg <= cfg_wdata[sfe_pkg::DELAY_W-1:0];
            else if (cfg_addr == sfe_pkg::REG_GAIN)
                gain_reg <= cfg_wdata[sfe_pkg::GAIN_W-1:0];
        end
    end

    assign gain_eff  = (gain_reg > sfe_pkg::GAIN_ONE) ? sfe_pkg::GAIN_ONE : gain_reg;
    assign delay_ext = CMP_W'(delay_reg);

    always_comb
    begin
        priority if (delay_ext < sfe_pkg::LEN_MIN)
            len_eff = sfe_pkg::LEN_MIN;
        else if (delay_ext > LEN_MAX)
            len_eff = LEN_MAX;
        else
            len_eff = delay_ext;
    end

    // handshake and stage enables
    assign s2_en   = out_en || !s2_v_reg;
    assign s1_en   = s2_en || !s1_v_reg;
    assign in_acc  = s_axis_tvalid && s1_en;
    assign s1_move = s1_v_reg && s2_en;
    assign s2_move = s2_v_reg && out_en;
    assign s_axis_tready = s1_en;

    // pointer wrap and fill count
    assign pos_inc   = CMP_W'(pos_reg) + CMP_W'(1);
    assign pos_next  = (pos_inc >= len_eff) ? '0 : pos_inc[ADDR_W-1:0];
    assign fill_next = (pos_inc > fill_reg) ? pos_inc : fill_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            fill_reg <= '0;
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            lw_v_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                pos_reg  <= pos_next;
                fill_reg <= fill_next;
            end
            if (s1_en)
            begin
                s1_v_reg <= in_acc;
            end
            if (s2_en)
            begin
                s2_v_reg <= s1_v_reg;
            end
            if (s2_move)
            begin
                lw_v_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_addr_reg    <= pos_reg;
            s1_written_reg <= CMP_W'(pos_reg) < fill_reg;
            s1_last_reg    <= s_axis_tlast;
        end
        if (s1_move)
        begin
            s2_addr_reg <= s1_addr_reg;
            s2_last_reg <= s1_last_reg;
        end
        if (s2_move)
        begin
            lw_addr_reg <= s2_addr_reg;
        end
    end

    assign ctrl.s1_load = in_acc;
    assign ctrl.s2_load = s1_move;
    assign ctrl.lw_load = s2_move;
    assign ctrl.s2_hit  = s2_v_reg && (s2_addr_reg == s1_addr_reg);
    assign ctrl.lw_hit  = lw_v_reg && (lw_addr_reg == s1_addr_reg);
    assign ctrl.written = s1_written_reg;

    sfe_ram #(
        .WIDTH (2 * SAMPLE_BITS),
        .DEPTH (MAX_DELAY_FRAMES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (s2_move),
        .wr_addr (s2_addr_reg),
        .wr_data ({y_right, y_left}),
        .rd_en   (in_acc),
        .rd_addr (pos_reg),
        .rd_data (rd_data)
    );

    sfe_lane #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_left (
        .clk     (clk),
        .ctrl    (ctrl),
        .gain    (gain_eff),
        .x_in    (s_axis_tdata[SAMPLE_BITS-1:0]),
        .rd_data (rd_data[SAMPLE_BITS-1:0]),
        .y       (y_left)
    );

    sfe_lane #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_right (
        .clk     (clk),
        .ctrl    (ctrl),
        .gain    (gain_eff),
        .x_in    (s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .rd_data (rd_data[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .y       (y_right)
    );

    sfe_out #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s2_v_reg),
        .in_left       (y_left),
        .in_right      (y_right),
        .in_last       (s2_last_reg),
        .in_ready      (out_en),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

@@ hw/rtl/sfe_checker.sv @@
// port level assertions of the stereo feedback echo and their bind
module sfe_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 s_axis_tvalid,
    input logic                                 s_axis_tready,
    input logic                                 m_axis_tvalid,
    input logic                                 m_axis_tready,
    input logic [((2*SAMPLE_BITS+7)/8)*8-1:0]   m_axis_tdata,
    input logic                                 m_axis_tlast
);

    logic       in_acc;
    logic       out_acc;
    logic [2:0] count_reg;
    logic [2:0] count_next;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        count_next = count_reg;
        if (in_acc && !out_acc)
            count_next = count_reg + 3'd1;
        else if (out_acc && !in_acc)
            count_next = count_reg - 3'd1;
    end

    // words in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc ##1 m_axis_tready ##1 m_axis_tready |=> m_axis_tvalid)
        else $error("word did not reach the output in time");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
        else $error("input stalled while output side free");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= 3'd3) && (!m_axis_tvalid || count_reg != 3'd0))
        else $error("output words do not match accepted words");

endmodule

bind stereo_feedback_echo sfe_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_sfe_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

@@ tb/stereo_feedback_echo_tb.sv @@
// self-checking testbench for the stereo feedback echo, with a frame-level echo predictor
`timescale 1ns / 1ps

module stereo_feedback_echo_tb;

    localparam int DATA_W      = 32;
    localparam int STORE_DEPTH = 32768;
    localparam int PHASES      = 10;
    localparam int PHASE_WORDS = 100;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 8;

    localparam logic [sfe_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [sfe_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic               last;
    } frame_t;

    class echo_scoreboard;
        logic signed [15:0]           held_left [0:STORE_DEPTH-1];
        logic signed [15:0]           held_right [0:STORE_DEPTH-1];
        logic [14:0]                  echo_pos;
        logic [sfe_pkg::DELAY_W-1:0]  delay_frames;
        logic [sfe_pkg::GAIN_W-1:0]   feedback_gain;
        frame_t                       expected_words[$];
        int                           errors;
        int                           frames_noted;
        int                           words_checked;

        function new();
            for (int i = 0; i < STORE_DEPTH; i++)
            begin
                held_left[i]  = '0;
                held_right[i] = '0;
            end
            echo_pos      = '0;
            delay_frames  = sfe_pkg::DELAY_RESET;
            feedback_gain = sfe_pkg::GAIN_RESET;
            errors        = 0;
            frames_noted  = 0;
            words_checked = 0;
        endfunction

        task report(string msg);
            if (errors < 40)
                $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function void write_reg(logic [sfe_pkg::CFG_IDX_W-1:0] idx,
                                logic [sfe_pkg::CFG_DATA_W-1:0] val);
            if (idx == sfe_pkg::REG_DELAY)
                delay_frames = val[sfe_pkg::DELAY_W-1:0];
            else if (idx == sfe_pkg::REG_GAIN)
                feedback_gain = val[sfe_pkg::GAIN_W-1:0];
        endfunction

        // x + round(gain * held / 2^16), ties upward, saturated to 16 bits
        function logic signed [15:0] echo_sample(logic signed [15:0] x,
                                                 logic signed [15:0] held,
                                                 logic [sfe_pkg::GAIN_W-1:0] g);
            longint held_l;
            longint gain_l;
            longint term;
            longint y;
            held_l = longint'(held);
            gain_l = longint'(g);
            term   = (held_l * gain_l + 64'sd32768) >>> sfe_pkg::SCALE;
            y      = longint'(x) + term;
            if (y > 32767)
                y = 32767;
            if (y < -32768)
                y = -32768;
            return y[15:0];
        endfunction

        function void note_frame(frame_t f);
            int                          len;
            int                          p;
            logic [sfe_pkg::GAIN_W-1:0]  g;
            frame_t                      r;
            len = int'(delay_frames);
            if (len < 1)
                len = 1;
            if (len > STORE_DEPTH)
                len = STORE_DEPTH;
            g = (feedback_gain > sfe_pkg::GAIN_ONE) ? sfe_pkg::GAIN_ONE : feedback_gain;
            p = int'(echo_pos);
            r.left  = echo_sample(f.left, held_left[p], g);
            r.right = echo_sample(f.right, held_right[p], g);
            r.last  = f.last;
            held_left[p]  = r.left;
            held_right[p] = r.right;
            echo_pos = (p + 1 >= len) ? 15'd0 : 15'(p + 1);
            expected_words.insert(expected_words.size(), r);
            frames_noted++;
        endfunction

        task check_frame(logic [DATA_W-1:0] data, logic last);
            frame_t want;
            if (expected_words.size() == 0)
            begin
                report($sformatf("word %h last %b with nothing pending", data, last));
                return;
            end
            want = expected_words.pop_front();
            words_checked++;
            if (data[15:0] !== want.left)
                report($sformatf("word %0d left got %0d want %0d", words_checked,
                                 $signed(data[15:0]), want.left));
            if (data[31:16] !== want.right)
                report($sformatf("word %0d right got %0d want %0d", words_checked,
                                 $signed(data[31:16]), want.right));
            if (last !== want.last)
                report($sformatf("word %0d tlast got %b want %b", words_checked,
                                 last, want.last));
        endtask

        task flag_leftovers();
            if (expected_words.size() != 0)
                report($sformatf("%0d words never arrived", expected_words.size()));
        endtask
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [DATA_W-1:0]               s_axis_tdata;
    logic                            s_axis_tlast;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [DATA_W-1:0]               m_axis_tdata;
    logic                            m_axis_tlast;
    logic                            cfg_we;
    logic [sfe_pkg::CFG_IDX_W-1:0]   cfg_addr;
    logic [sfe_pkg::CFG_DATA_W-1:0]  cfg_wdata;

    echo_scoreboard sb = new();
    bit             allow_idle;
    int             stall_left;
    int             cycle_count;
    int             cfg_writes;

    stereo_feedback_echo dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // sink side: random stall bursts
    initial
    begin
        m_axis_tready = 1'b0;
        stall_left    = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                m_axis_tready = 1'b0;
                stall_left--;
            end
            else if (allow_idle && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready = 1'b0;
                stall_left    = $urandom_range(0, 9);
            end
            else
                m_axis_tready = 1'b1;
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_frame(m_axis_tdata, m_axis_tlast);
        end
    end

    task send_frame(frame_t f);
        int gap;
        gap = (allow_idle && $urandom_range(0, 4) == 0) ? $urandom_range(1, 10) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tdata  = {f.right, f.left};
        s_axis_tlast  = f.last;
        s_axis_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_frame(f);
    endtask

    task wait_drained();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (sb.expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task write_reg(logic [sfe_pkg::CFG_IDX_W-1:0] idx, logic [sfe_pkg::CFG_DATA_W-1:0] val);
        wait_drained();
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = val;
        @(posedge clk);
        sb.write_reg(idx, val);
        cfg_writes++;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function logic signed [15:0] pick_sample();
        case ($urandom_range(0, 11))
            0:       return 16'sh7fff;
            1:       return -16'sh8000;
            2:       return 16'sh0000;
            3:       return -16'sh0001;
            default: return 16'($urandom);
        endcase
    endfunction

    function frame_t random_frame();
        frame_t f;
        f.left  = pick_sample();
        f.right = pick_sample();
        f.last  = ($urandom_range(0, 7) == 0);
        return f;
    endfunction

    function frame_t make_frame(logic signed [15:0] l, logic signed [15:0] r, logic last);
        frame_t f;
        f.left  = l;
        f.right = r;
        f.last  = last;
        return f;
    endfunction

    function logic [sfe_pkg::CFG_DATA_W-1:0] random_delay();
        case ($urandom_range(0, 9))
            0:       return sfe_pkg::CFG_DATA_W'($urandom_range(0, 3));
            1:       return 17'd32768;
            2:       return 17'd65535;
            3:       return sfe_pkg::CFG_DATA_W'($urandom_range(0, 17'h1ffff));
            4:       return sfe_pkg::CFG_DATA_W'($urandom_range(2, 32768));
            default: return sfe_pkg::CFG_DATA_W'($urandom_range(2, 40));
        endcase
    endfunction

    function logic [sfe_pkg::CFG_DATA_W-1:0] random_gain();
        case ($urandom_range(0, 7))
            0:       return 17'd0;
            1:       return sfe_pkg::GAIN_ONE;
            2:       return sfe_pkg::CFG_DATA_W'($urandom_range(17'h10001, 17'h1ffff));
            3:       return sfe_pkg::CFG_DATA_W'($urandom_range(0, 17'h1ffff));
            default: return sfe_pkg::CFG_DATA_W'($urandom_range(30000, 65536));
        endcase
    endfunction

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = sfe_pkg::REG_DELAY;
        cfg_wdata     = '0;
        cycle_count   = 0;
        cfg_writes    = 0;
        allow_idle    = 1'b1;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset defaults, field extremes
        send_frame(make_frame(16'sh7fff, -16'sh8000, 1'b1));
        send_frame(make_frame(-16'sh8000, 16'sh7fff, 1'b0));
        send_frame(make_frame(-16'sh0001, 16'sh0000, 1'b1));

        // single-entry delay at unity gain drives both saturation limits
        write_reg(sfe_pkg::REG_DELAY, 17'd1);
        write_reg(sfe_pkg::REG_GAIN, sfe_pkg::GAIN_ONE);
        send_frame(make_frame(16'sh7fff, -16'sh8000, 1'b0));
        send_frame(make_frame(16'sh7fff, -16'sh8000, 1'b0));
        send_frame(make_frame(-16'sh8000, 16'sh7fff, 1'b1));
        send_frame(make_frame(16'sh0001, -16'sh0001, 1'b0));

        // zero delay, gain above unity
        write_reg(sfe_pkg::REG_DELAY, 17'd0);
        write_reg(sfe_pkg::REG_GAIN, 17'h1ffff);
        send_frame(make_frame(16'sh4000, -16'sh4000, 1'b0));
        send_frame(make_frame(16'sh0000, 16'sh0000, 1'b0));
        send_frame(make_frame(-16'sh7fff, 16'sh1234, 1'b1));

        // shortest real delay, zero gain
        write_reg(sfe_pkg::REG_DELAY, 17'd2);
        write_reg(sfe_pkg::REG_GAIN, 17'd0);
        for (int i = 0; i < 3; i++)
            send_frame(random_frame());

        // writes to spare indexes change nothing
        write_reg(REG_SPARE_A, 17'h1ffff);
        write_reg(REG_SPARE_B, 17'h0aaaa);

        // shrink the delay while the pointer sits past the new length
        write_reg(sfe_pkg::REG_GAIN, 17'd40000);
        write_reg(sfe_pkg::REG_DELAY, 17'd12);
        for (int i = 0; i < 10; i++)
            send_frame(random_frame());
        write_reg(sfe_pkg::REG_DELAY, 17'd4);
        send_frame(random_frame());
        send_frame(random_frame());

        for (int ph = 0; ph < PHASES; ph++)
        begin
            allow_idle = (ph != 4) && (ph != PHASES - 1);
            write_reg(sfe_pkg::REG_DELAY, random_delay());
            write_reg(sfe_pkg::REG_GAIN, random_gain());
            for (int k = 0; k < PHASE_WORDS; k++)
            begin
                if (ph == 2 && k == 50)
                    wait_drained();
                send_frame(random_frame());
            end
        end

        @(negedge clk);
        s_axis_tvalid = 1'b0;
        allow_idle    = 1'b0;
        while (sb.expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        sb.flag_leftovers();

        $display("%0d frames sent, %0d words checked, %0d register writes",
                 sb.frames_noted, sb.words_checked, cfg_writes);
        $display("exercised short, shrunk and random delays and gains up to above unity");
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
